FILE: design/kva_pkg.sv
// Shared types, constants and key tables for the keyboard voice allocator.
package kva_pkg;

	// Voice table geometry
	localparam int VOICES     = 8;
	localparam int WAVE_COUNT = 4;
	localparam int IDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int NOTE_KEYS  = 30;
	localparam int KIDX_W     = 5;

	// Field widths of one voice
	localparam int NOTE_W  = 7;
	localparam int WAVE_W  = 4;
	localparam int LEVEL_W = 8;
	localparam int ST_W    = 2;
	localparam int AGE_W   = 32;
	localparam int OCT_W   = 3;

	// Command codes
	localparam logic [1:0] CMD_DOWN = 2'd0;
	localparam logic [1:0] CMD_UP   = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Voice states
	localparam logic [ST_W-1:0] VS_OFF      = 2'd0;
	localparam logic [ST_W-1:0] VS_HELD     = 2'd1;
	localparam logic [ST_W-1:0] VS_RELEASED = 2'd2;

	// Function key usage codes
	localparam logic [8:0] KEY_HOME = 9'd74;
	localparam logic [8:0] KEY_END  = 9'd77;
	localparam logic [8:0] KEY_F1   = 9'd58;
	localparam logic [8:0] KEY_F2   = 9'd59;
	localparam logic [8:0] KEY_F3   = 9'd60;
	localparam logic [8:0] KEY_F4   = 9'd61;
	localparam logic [8:0] KEY_F5   = 9'd62;
	localparam logic [8:0] KEY_F6   = 9'd63;

	// Octave and level limits
	localparam logic [OCT_W-1:0]   OCT_MIN   = 3'd1;
	localparam logic [OCT_W-1:0]   OCT_MAX   = 3'd6;
	localparam logic [OCT_W-1:0]   OCT_RST   = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = 8'd8;
	localparam logic [NOTE_W-1:0]  NOTE_OFS  = 7'd10;
	localparam logic [NOTE_W-1:0]  SEMIS     = 7'd12;

	// Decoded function of a key
	typedef enum logic [3:0] {
		FN_NONE,
		FN_OCT_UP,
		FN_OCT_DN,
		FN_CAR_UP,
		FN_CAR_DN,
		FN_MOD_UP,
		FN_MOD_DN,
		FN_LVL_UP,
		FN_LVL_DN
	} key_fn_t;

	typedef struct packed {
		key_fn_t           fn;
		logic              is_note;
		logic [KIDX_W-1:0] key_idx;
	} key_dec_t;

	// One voice table entry
	typedef struct packed {
		logic [NOTE_W-1:0]  note;
		logic [WAVE_W-1:0]  car;
		logic [WAVE_W-1:0]  modw;
		logic [LEVEL_W-1:0] level;
		logic [ST_W-1:0]    st;
		logic [AGE_W-1:0]   age;
	} voice_t;

	localparam int ENTRY_W = $bits(voice_t);

	// Usage code of each note key, ascending pitch
	function automatic logic [8:0] note_code(input int i);
		logic [8:0] c;
		case (i)
			0:       c = 9'd4;
			1:       c = 9'd29;
			2:       c = 9'd22;
			3:       c = 9'd27;
			4:       c = 9'd7;
			5:       c = 9'd6;
			6:       c = 9'd25;
			7:       c = 9'd10;
			8:       c = 9'd5;
			9:       c = 9'd11;
			10:      c = 9'd17;
			11:      c = 9'd13;
			12:      c = 9'd16;
			13:      c = 9'd20;
			14:      c = 9'd31;
			15:      c = 9'd26;
			16:      c = 9'd32;
			17:      c = 9'd8;
			18:      c = 9'd21;
			19:      c = 9'd34;
			20:      c = 9'd23;
			21:      c = 9'd35;
			22:      c = 9'd28;
			23:      c = 9'd36;
			24:      c = 9'd24;
			25:      c = 9'd12;
			26:      c = 9'd38;
			27:      c = 9'd18;
			28:      c = 9'd39;
			29:      c = 9'd19;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	// Wave select stepping, wrapping both ways
	function automatic logic [WAVE_W-1:0] wave_up(input logic [WAVE_W-1:0] w);
		return (w == WAVE_W'(WAVE_COUNT - 1)) ? '0 : w + WAVE_W'(1);
	endfunction

	function automatic logic [WAVE_W-1:0] wave_down(input logic [WAVE_W-1:0] w);
		return (w == '0) ? WAVE_W'(WAVE_COUNT - 1) : w - WAVE_W'(1);
	endfunction

endpackage

FILE: design/kva_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module kva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/kva_keydec.sv
// Scancode decoder: function keys and note key index.
module kva_keydec
	import kva_pkg::*;
(
	input  logic [8:0] scancode,
	output key_dec_t   dec
);

	// Function keys, then note key match; codes are unique so the hits are disjoint
	always_comb begin
		case (scancode)
			KEY_HOME: dec.fn = FN_OCT_UP;
			KEY_END:  dec.fn = FN_OCT_DN;
			KEY_F1:   dec.fn = FN_CAR_UP;
			KEY_F2:   dec.fn = FN_CAR_DN;
			KEY_F3:   dec.fn = FN_MOD_UP;
			KEY_F4:   dec.fn = FN_MOD_DN;
			KEY_F5:   dec.fn = FN_LVL_UP;
			KEY_F6:   dec.fn = FN_LVL_DN;
			default:  dec.fn = FN_NONE;
		endcase
		dec.is_note = 1'b0;
		dec.key_idx = '0;
		for (int i = 0; i < NOTE_KEYS; i++) begin
			if (scancode == note_code(i)) begin
				dec.is_note = 1'b1;
				dec.key_idx = KIDX_W'(i);
			end
		end
	end

endmodule

FILE: design/keyboard_voice_allocator.sv
// Keyboard voice allocator: top level with voice table walker.
// Note key-down and parameter keys finish in the accepting cycle; busy stays low.
// Octave keys, key-up of a note key and tick walk the voice table: busy until
// the walk ends (key-up may stop early at its match), one RAM entry per cycle.
// A tick gives VOICES results, one per cycle.
// Reset clears control and per-entry valid bits, so every voice reads as off at once.
module keyboard_voice_allocator
	import kva_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [8:0]         scancode,
	output logic               result_valid,
	output logic [5:0]         voice_index,
	output logic [NOTE_W-1:0]  note_number,
	output logic [WAVE_W-1:0]  carrier_wave,
	output logic [WAVE_W-1:0]  modulator_wave,
	output logic [LEVEL_W-1:0] level_eighths,
	output logic [ST_W-1:0]    voice_state,
	output logic [AGE_W-1:0]   voice_age,
	output logic               last_voice
);

	typedef enum logic {ST_IDLE, ST_WALK} state_t;
	typedef enum logic [1:0] {OP_REL, OP_KEYUP, OP_TICK} op_t;

	state_t             state_q;
	op_t                op_q;
	logic [CNT_W-1:0]   rd_q;
	logic [NOTE_W-1:0]  note_q;
	logic [OCT_W-1:0]   octave_q;
	logic [WAVE_W-1:0]  car_q;
	logic [WAVE_W-1:0]  mod_q;
	logic [LEVEL_W-1:0] level_q;
	logic [IDX_W-1:0]   slot_q;
	logic [VOICES-1:0]  valid_q;

	logic               rvld_s1;
	logic               ev_s1;
	logic [IDX_W-1:0]   raddr_s1;

	key_dec_t           dec;
	logic               accept;
	logic               note_wr;
	logic [IDX_W-1:0]   slot_next;
	logic [NOTE_W-1:0]  note_calc;
	logic               issue;
	logic               finish;
	logic               walk_wr;
	logic               keyup_hit;
	logic               at_last;
	logic [ENTRY_W-1:0] ram_rdata;
	voice_t             cur;
	voice_t             upd;
	voice_t             fresh;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	voice_t             wdata;

	kva_keydec u_keydec (
		.scancode (scancode),
		.dec      (dec)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Note number from key index and current octave
	assign note_calc = NOTE_W'(dec.key_idx) + SEMIS * NOTE_W'(octave_q) - NOTE_OFS;
	assign slot_next = (slot_q == IDX_W'(VOICES - 1)) ? '0 : slot_q + IDX_W'(1);
	assign note_wr   = accept && (command == CMD_DOWN) && (dec.fn == FN_NONE) && dec.is_note;

	always_comb begin
		fresh       = '0;
		fresh.note  = note_calc;
		fresh.car   = car_q;
		fresh.modw  = mod_q;
		fresh.level = level_q;
		fresh.st    = VS_HELD;
	end

	// Read-modify-write of the entry read last cycle
	assign cur       = ev_s1 ? voice_t'(ram_rdata) : voice_t'('0);
	assign at_last   = (raddr_s1 == IDX_W'(VOICES - 1));
	assign keyup_hit = (op_q == OP_KEYUP) && (cur.st == VS_HELD) && (cur.note == note_q);

	always_comb begin
		upd     = cur;
		walk_wr = 1'b0;
		case (op_q)
			OP_REL: begin
				upd.st  = VS_RELEASED;
				walk_wr = (cur.st == VS_HELD);
			end
			OP_KEYUP: begin
				upd.st  = VS_RELEASED;
				walk_wr = keyup_hit;
			end
			OP_TICK: begin
				if (cur.st != VS_OFF && cur.age != '1) begin
					upd.age = cur.age + AGE_W'(1);
				end
				walk_wr = 1'b1;
			end
			default: begin
				walk_wr = 1'b0;
			end
		endcase
	end

	assign finish = (state_q == ST_WALK) && rvld_s1 && (keyup_hit || at_last);
	assign issue  = (state_q == ST_WALK) && (rd_q < CNT_W'(VOICES)) && !finish;

	// Write port: walker write-back or new note
	always_comb begin
		if ((state_q == ST_WALK) && rvld_s1 && walk_wr) begin
			we    = 1'b1;
			waddr = raddr_s1;
			wdata = upd;
		end else begin
			we    = note_wr;
			waddr = slot_next;
			wdata = fresh;
		end
	end

	kva_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (VOICES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Per-entry valid bits; an unwritten entry reads as an off voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= rd_q[IDX_W-1:0];
		ev_s1    <= valid_q[rd_q[IDX_W-1:0]];
	end

	// Sequencer, parameter registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_TICK;
			rd_q           <= '0;
			note_q         <= '0;
			octave_q       <= OCT_RST;
			car_q          <= '0;
			mod_q          <= '0;
			level_q        <= LEVEL_RST;
			slot_q         <= '0;
			result_valid   <= 1'b0;
			voice_index    <= '0;
			note_number    <= '0;
			carrier_wave   <= '0;
			modulator_wave <= '0;
			level_eighths  <= '0;
			voice_state    <= '0;
			voice_age      <= '0;
			last_voice     <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_q <= '0;
					if (accept) begin
						case (command)
							CMD_DOWN: begin
								case (dec.fn)
									FN_OCT_UP: begin
										if (octave_q < OCT_MAX) octave_q <= octave_q + OCT_W'(1);
										op_q    <= OP_REL;
										state_q <= ST_WALK;
									end
									FN_OCT_DN: begin
										if (octave_q > OCT_MIN) octave_q <= octave_q - OCT_W'(1);
										op_q    <= OP_REL;
										state_q <= ST_WALK;
									end
									FN_CAR_UP: car_q <= wave_up(car_q);
									FN_CAR_DN: car_q <= wave_down(car_q);
									FN_MOD_UP: mod_q <= wave_up(mod_q);
									FN_MOD_DN: mod_q <= wave_down(mod_q);
									FN_LVL_UP: begin
										if (level_q < LEVEL_MAX) level_q <= level_q + LEVEL_W'(1);
									end
									FN_LVL_DN: begin
										if (level_q > LEVEL_MIN) level_q <= level_q - LEVEL_W'(1);
									end
									default: begin
										if (dec.is_note) slot_q <= slot_next;
									end
								endcase
							end
							CMD_UP: begin
								if (dec.is_note) begin
									note_q  <= note_calc;
									op_q    <= OP_KEYUP;
									state_q <= ST_WALK;
								end
							end
							CMD_TICK: begin
								op_q    <= OP_TICK;
								state_q <= ST_WALK;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (issue) rd_q <= rd_q + CNT_W'(1);
					if (rvld_s1 && (op_q == OP_TICK)) begin
						result_valid   <= 1'b1;
						voice_index    <= 6'(raddr_s1);
						note_number    <= upd.note;
						carrier_wave   <= upd.car;
						modulator_wave <= upd.modw;
						level_eighths  <= upd.level;
						voice_state    <= upd.st;
						voice_age      <= upd.age;
						last_voice     <= at_last;
					end
					if (finish) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/kva_checker.sv
// Port-level checks of the tick table dump, bound to the top level.
module kva_checker
	import kva_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       command,
	input logic             result_valid,
	input logic [5:0]       voice_index,
	input logic [ST_W-1:0]  voice_state,
	input logic             last_voice
);

	// A dump runs one item per cycle until the final voice
	a_dump_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_voice |=> result_valid)
		else $error("voice dump broke before the final voice");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_voice |=> !result_valid)
		else $error("result follows the final voice directly");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_voice |=> voice_index == $past(voice_index) + 6'd1)
		else $error("voice index did not step by one");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_TICK |=> busy)
		else $error("tick accepted without going busy");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> voice_state == VS_OFF || voice_state == VS_HELD ||
			voice_state == VS_RELEASED)
		else $error("reported voice state is not a defined code");

endmodule

bind keyboard_voice_allocator kva_checker u_kva_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.voice_index  (voice_index),
	.voice_state  (voice_state),
	.last_voice   (last_voice)
);
